@@ rtl/vtpc_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpc_pkg: shared types and constants for the version tag parser
// Character codes, tag length limit and parse phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpc_pkg;

  localparam int unsigned MaxTagLen = 64;
  localparam int unsigned CharW     = 16;
  localparam int unsigned NumW      = 32;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned SufPosW   = 3;
  localparam int unsigned SufLen    = 7;

  localparam logic [CharW-1:0] ChV    = 16'h0076;
  localparam logic [CharW-1:0] ChDot  = 16'h002E;
  localparam logic [CharW-1:0] ChDash = 16'h002D;
  localparam logic [CharW-1:0] ChZero = 16'h0030;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCurMajor = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgCurMinor = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgCurPatch = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgCurBuild = 8'd3;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_V      = 6'b000001,
    PH_MAJOR  = 6'b000010,
    PH_MINOR  = 6'b000100,
    PH_PATCH  = 6'b001000,
    PH_SUFFIX = 6'b010000,
    PH_BUILD  = 6'b100000
  } phase_e;

  // Characters of the "-build." suffix by position
  function automatic logic [CharW-1:0] suffix_char(input logic [SufPosW-1:0] pos);
    logic [CharW-1:0] ch;
    case (pos)
      3'd0:    ch = 16'h002D;
      3'd1:    ch = 16'h0062;
      3'd2:    ch = 16'h0075;
      3'd3:    ch = 16'h0069;
      3'd4:    ch = 16'h006C;
      3'd5:    ch = 16'h0064;
      3'd6:    ch = 16'h002E;
      default: ch = 16'h0000;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/version_tag_parse_compare.sv @@
// ----------------------------------------------------------------------------
// version_tag_parse_compare: streaming version tag parser and comparator
// Parses "vMAJOR.MINOR.PATCH-build.BUILD" one character per request and
// reports the numbers and whether the tag is newer than the installed one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character per request (char_code_i, last_char_i),
//   taken when in_valid_i is high and in_stall_o is low. Every character
//   updates the parse state in the cycle it is taken, so one character
//   per cycle is sustained unless a held result stalls the input.
//   Output channel: one result per tag, registered. It appears on
//   out_valid_o in the cycle after the last character is taken and holds
//   while out_stall_i is high.
//   Throughput: 1 character per cycle while in_stall_o is low.
//   Stall: in_stall_o rises while a result is held by out_stall_i; the
//   input resumes in the cycle the result is taken.
//   Configuration: cfg_valid_i/cfg_ready_o write the installed version
//   (index 0..3 = major, minor, patch, build); other indexes are ignored.
//   Write only while no tag is in flight.
//   Reset: all parse state, the installed version and the output valid
//   clear at once; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module version_tag_parse_compare (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // character input
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [vtpc_pkg::CharW-1:0]   char_code_i,
  input  wire logic                         last_char_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              tag_ok_o,
  output logic [vtpc_pkg::NumW-1:0]         ver_major_o,
  output logic [vtpc_pkg::NumW-1:0]         ver_minor_o,
  output logic [vtpc_pkg::NumW-1:0]         ver_patch_o,
  output logic [vtpc_pkg::NumW-1:0]         ver_build_o,
  output logic                              is_newer_o,
  // configuration write
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [vtpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [vtpc_pkg::NumW-1:0]    cfg_data_i
);
  import vtpc_pkg::*;

  // installed version
  logic [NumW-1:0] cur_major_q, cur_minor_q, cur_patch_q, cur_build_q;

  // parse state
  phase_e              phase_q, phase_d;
  logic [SufPosW-1:0]  suf_pos_q, suf_pos_d;
  logic [NumW-1:0]     accum_q, accum_d;
  logic [1:0]          dcount_q, dcount_d;
  logic                lead_zero_q, lead_zero_d;
  logic [NumW-1:0]     held_major_q, held_major_d;
  logic [NumW-1:0]     held_minor_q, held_minor_d;
  logic [NumW-1:0]     held_patch_q, held_patch_d;
  logic [CountW-1:0]   char_cnt_q, char_cnt_d;
  logic                failed_q, failed_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                tag_ok_q, tag_ok_d;
  logic [NumW-1:0]     ver_major_q, ver_major_d;
  logic [NumW-1:0]     ver_minor_q, ver_minor_d;
  logic [NumW-1:0]     ver_patch_q, ver_patch_d;
  logic [NumW-1:0]     ver_build_q, ver_build_d;
  logic                is_newer_q, is_newer_d;

  logic                in_fire, out_fire;
  logic                is_digit;
  logic [3:0]          digit;
  logic [NumW+3:0]     acc_next;
  logic                ok;
  logic                newer;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;

  // Decode digit and build accum * 10 + digit
  assign is_digit = (char_code_i[CharW-1:4] == ChZero[CharW-1:4]) &&
                    (char_code_i[3:0] <= 4'd9);
  assign digit    = char_code_i[3:0];
  assign acc_next = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} +
                    {{NumW{1'b0}}, digit};

  // Parse one character
  always_comb begin
    phase_d      = phase_q;
    suf_pos_d    = suf_pos_q;
    accum_d      = accum_q;
    dcount_d     = dcount_q;
    lead_zero_d  = lead_zero_q;
    held_major_d = held_major_q;
    held_minor_d = held_minor_q;
    held_patch_d = held_patch_q;
    failed_d     = failed_q;
    char_cnt_d   = char_cnt_q;

    if (char_cnt_q >= CountW'(MaxTagLen)) begin
      failed_d = 1'b1;
    end
    if (char_cnt_q != {CountW{1'b1}}) begin
      char_cnt_d = char_cnt_q + CountW'(1);
    end

    if (!failed_d) begin
      case (phase_q)
        PH_V: begin
          if (char_code_i == ChV) begin
            phase_d = PH_MAJOR;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_MAJOR, PH_MINOR, PH_PATCH, PH_BUILD: begin
          if (is_digit) begin
            // take a digit: check leading zero, overflow, bump count
            if (dcount_q == 2'd0) begin
              lead_zero_d = (digit == 4'd0);
            end else if (lead_zero_q) begin
              failed_d = 1'b1;
            end
            if (acc_next[NumW+3:NumW] != 4'd0) begin
              failed_d = 1'b1;
            end
            accum_d = acc_next[NumW-1:0];
            if (dcount_q != 2'd2) begin
              dcount_d = dcount_q + 2'd1;
            end
          end else if (dcount_q != 2'd0 && phase_q == PH_MAJOR && char_code_i == ChDot) begin
            held_major_d = accum_q;
            accum_d      = '0;
            dcount_d     = 2'd0;
            lead_zero_d  = 1'b0;
            phase_d      = PH_MINOR;
          end else if (dcount_q != 2'd0 && phase_q == PH_MINOR && char_code_i == ChDot) begin
            held_minor_d = accum_q;
            accum_d      = '0;
            dcount_d     = 2'd0;
            lead_zero_d  = 1'b0;
            phase_d      = PH_PATCH;
          end else if (dcount_q != 2'd0 && phase_q == PH_PATCH && char_code_i == ChDash) begin
            held_patch_d = accum_q;
            accum_d      = '0;
            dcount_d     = 2'd0;
            lead_zero_d  = 1'b0;
            suf_pos_d    = SufPosW'(1);
            phase_d      = PH_SUFFIX;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_SUFFIX: begin
          if (suf_pos_q < SufPosW'(SufLen) && char_code_i == suffix_char(suf_pos_q)) begin
            if (suf_pos_q == SufPosW'(SufLen - 1)) begin
              suf_pos_d = '0;
              phase_d   = PH_BUILD;
            end else begin
              suf_pos_d = suf_pos_q + SufPosW'(1);
            end
          end else begin
            failed_d = 1'b1;
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end
  end

  // Compare the finished tag against the installed version
  assign ok = !failed_d && phase_d == PH_BUILD && dcount_d != 2'd0;

  always_comb begin
    if (held_major_q != cur_major_q) begin
      newer = held_major_q > cur_major_q;
    end else if (held_minor_q != cur_minor_q) begin
      newer = held_minor_q > cur_minor_q;
    end else if (held_patch_q != cur_patch_q) begin
      newer = held_patch_q > cur_patch_q;
    end else begin
      newer = accum_d > cur_build_q;
    end
  end

  // Load the result register on the last character, drop it when taken
  always_comb begin
    out_valid_d = out_valid_q;
    tag_ok_d    = tag_ok_q;
    ver_major_d = ver_major_q;
    ver_minor_d = ver_minor_q;
    ver_patch_d = ver_patch_q;
    ver_build_d = ver_build_q;
    is_newer_d  = is_newer_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && last_char_i) begin
      out_valid_d = 1'b1;
      tag_ok_d    = ok;
      ver_major_d = ok ? held_major_q : '0;
      ver_minor_d = ok ? held_minor_q : '0;
      ver_patch_d = ok ? held_patch_q : '0;
      ver_build_d = ok ? accum_d : '0;
      is_newer_d  = ok && newer;
    end
  end

  // Parse state: advance per character, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_V;
      suf_pos_q    <= '0;
      accum_q      <= '0;
      dcount_q     <= 2'd0;
      lead_zero_q  <= 1'b0;
      held_major_q <= '0;
      held_minor_q <= '0;
      held_patch_q <= '0;
      char_cnt_q   <= '0;
      failed_q     <= 1'b0;
    end else if (in_fire) begin
      if (last_char_i) begin
        phase_q      <= PH_V;
        suf_pos_q    <= '0;
        accum_q      <= '0;
        dcount_q     <= 2'd0;
        lead_zero_q  <= 1'b0;
        held_major_q <= '0;
        held_minor_q <= '0;
        held_patch_q <= '0;
        char_cnt_q   <= '0;
        failed_q     <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        suf_pos_q    <= suf_pos_d;
        accum_q      <= accum_d;
        dcount_q     <= dcount_d;
        lead_zero_q  <= lead_zero_d;
        held_major_q <= held_major_d;
        held_minor_q <= held_minor_d;
        held_patch_q <= held_patch_d;
        char_cnt_q   <= char_cnt_d;
        failed_q     <= failed_d;
      end
    end
  end

  // Installed version registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_major_q <= '0;
      cur_minor_q <= '0;
      cur_patch_q <= '0;
      cur_build_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgCurMajor: cur_major_q <= cfg_data_i;
        CfgCurMinor: cur_minor_q <= cfg_data_i;
        CfgCurPatch: cur_patch_q <= cfg_data_i;
        CfgCurBuild: cur_build_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    tag_ok_q    <= tag_ok_d;
    ver_major_q <= ver_major_d;
    ver_minor_q <= ver_minor_d;
    ver_patch_q <= ver_patch_d;
    ver_build_q <= ver_build_d;
    is_newer_q  <= is_newer_d;
  end

  assign out_valid_o = out_valid_q;
  assign tag_ok_o    = tag_ok_q;
  assign ver_major_o = ver_major_q;
  assign ver_minor_o = ver_minor_q;
  assign ver_patch_o = ver_patch_q;
  assign ver_build_o = ver_build_q;
  assign is_newer_o  = is_newer_q;

endmodule

`default_nettype wire

@@ rtl/vtpc_checker.sv @@
// ----------------------------------------------------------------------------
// vtpc_checker: port-level checks for the version tag parser
// Watches the top-level ports and flags result and flow-control slips.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         last_char_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         tag_ok_o,
  input wire logic [vtpc_pkg::NumW-1:0]    ver_major_o,
  input wire logic [vtpc_pkg::NumW-1:0]    ver_minor_o,
  input wire logic [vtpc_pkg::NumW-1:0]    ver_patch_o,
  input wire logic [vtpc_pkg::NumW-1:0]    ver_build_o,
  input wire logic                         is_newer_o,
  input wire logic                         cfg_valid_i,
  input wire logic                         cfg_ready_o
);
  import vtpc_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tag_ok_o) &&
    $stable(ver_build_o) && $stable(is_newer_o))
    else $error("stalled result changed");

  // a new result only follows a taken last character
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_char_i))
    else $error("result without a last character");

  // a failed tag reports zero numbers and is never newer
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tag_ok_o |-> ver_major_o == '0 && ver_minor_o == '0 &&
    ver_patch_o == '0 && ver_build_o == '0 && !is_newer_o)
    else $error("failed tag carries data");

  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind version_tag_parse_compare vtpc_checker u_vtpc_checker (.*);

`default_nettype wire
